// ----- hw/rtl/mlptw_pkg.sv -----
// ============================================================================
// mlptw_pkg
// Shared types, codes and default sizes of the page table walker.
// ============================================================================
package mlptw_pkg;

  localparam int LEVEL_COUNT_DEF      = 4;
  localparam int PAGE_OFFSET_BITS_DEF = 12;
  localparam int FRAME_COUNT_DEF      = 256;

  localparam int VA_W     = 48;
  localparam int PHYS_W   = 20;
  localparam int STATUS_W = 2;
  localparam int PTE_BITS = 3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_ALLOCATE  = 1'b1;

  typedef struct packed {
    logic take;
    logic set_root;
  } pool_ctl_t;

  typedef struct packed {
    logic avail;
    logic root_present;
  } pool_sts_t;

endpackage

// ----- hw/rtl/mlptw_ram.sv -----
// ============================================================================
// mlptw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module mlptw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 131072,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/mlptw_pool.sv -----
// ============================================================================
// mlptw_pool
// Sequential frame pool and root table register.
// ============================================================================
module mlptw_pool #(
  parameter int FRAME_COUNT = mlptw_pkg::FRAME_COUNT_DEF,
  localparam int FB = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
  localparam int NW = $clog2(FRAME_COUNT + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mlptw_pkg::pool_ctl_t ctl,
  output mlptw_pkg::pool_sts_t sts,
  output logic [FB-1:0]        free_frame,
  output logic [FB-1:0]        root_frame
);

  logic [NW-1:0] next_free_r, next_free_nxt;
  logic          root_present_r, root_present_nxt;
  logic [FB-1:0] root_frame_r, root_frame_nxt;
  logic          avail;

  assign avail      = next_free_r < NW'(FRAME_COUNT);
  assign free_frame = next_free_r[FB-1:0];

  always_comb begin
    next_free_nxt    = next_free_r;
    root_present_nxt = root_present_r;
    root_frame_nxt   = root_frame_r;
    if (ctl.take && avail) begin
      next_free_nxt = next_free_r + NW'(1);
      if (ctl.set_root) begin
        root_present_nxt = 1'b1;
        root_frame_nxt   = free_frame;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r    <= '0;
      root_present_r <= 1'b0;
      root_frame_r   <= '0;
    end else begin
      next_free_r    <= next_free_nxt;
      root_present_r <= root_present_nxt;
      root_frame_r   <= root_frame_nxt;
    end
  end

  assign sts.avail        = avail;
  assign sts.root_present = root_present_r;
  assign root_frame       = root_frame_r;

endmodule

// ----- hw/rtl/mlptw_walk.sv -----
// ============================================================================
// mlptw_walk
// Walk sequencer: clearing sweep, per-level entry read, check and write-back.
// ============================================================================
module mlptw_walk #(
  parameter int LEVEL_COUNT      = mlptw_pkg::LEVEL_COUNT_DEF,
  parameter int PAGE_OFFSET_BITS = mlptw_pkg::PAGE_OFFSET_BITS_DEF,
  parameter int FRAME_COUNT      = mlptw_pkg::FRAME_COUNT_DEF,
  localparam int FB    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
  localparam int IDX_W = PAGE_OFFSET_BITS - mlptw_pkg::PTE_BITS,
  localparam int EW    = FB + 1,
  localparam int AW    = FB + IDX_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [mlptw_pkg::VA_W-1:0]       in_virt_addr,
  output logic                             out_valid,
  output logic [mlptw_pkg::PHYS_W-1:0]     out_phys_addr,
  output logic [mlptw_pkg::STATUS_W-1:0]   out_status,
  output mlptw_pkg::pool_ctl_t             pool_ctl,
  input  mlptw_pkg::pool_sts_t             pool_sts,
  input  logic [FB-1:0]                    free_frame,
  input  logic [FB-1:0]                    root_frame,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic [EW-1:0]                    mem_wdata,
  output logic [AW-1:0]                    mem_raddr,
  input  logic [EW-1:0]                    mem_rdata
);

  localparam int LW     = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int FULL_W = FB + PAGE_OFFSET_BITS;
  localparam int PW     = (FULL_W > mlptw_pkg::PHYS_W) ? FULL_W : mlptw_pkg::PHYS_W;
  localparam int DEPTH  = FRAME_COUNT * (2 ** IDX_W);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0]                           state_r, state_nxt;
  logic [LW-1:0]                        lv_r, lv_nxt;
  logic [FB-1:0]                        frame_r, frame_nxt;
  logic                                 type_r, type_nxt;
  logic [mlptw_pkg::VA_W-1:0]           va_r, va_nxt;
  logic [AW-1:0]                        addr_r, addr_nxt;
  logic [AW-1:0]                        clr_r, clr_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [mlptw_pkg::PHYS_W-1:0]         out_phys_r, out_phys_nxt;
  logic [mlptw_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;

  logic [IDX_W-1:0] idx_tab [LEVEL_COUNT];
  logic [IDX_W-1:0] idx_cur;
  logic [FB-1:0]    entry_frame;
  logic             entry_present;
  logic             last_level;
  logic [PW-1:0]    phys_full;

  for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_idx
    localparam int SH = PAGE_OFFSET_BITS + IDX_W * (LEVEL_COUNT - 1 - g);
    assign idx_tab[g] = IDX_W'(va_r >> SH);
  end

  assign idx_cur       = idx_tab[lv_r];
  assign entry_present = mem_rdata[0];
  assign entry_frame   = mem_rdata[EW-1:1];
  assign last_level    = lv_r == LW'(LEVEL_COUNT - 1);
  assign phys_full     = PW'({entry_frame, va_r[PAGE_OFFSET_BITS-1:0]});

  always_comb begin
    state_nxt      = state_r;
    lv_nxt         = lv_r;
    frame_nxt      = frame_r;
    type_nxt       = type_r;
    va_nxt         = va_r;
    addr_nxt       = addr_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = 1'b0;
    out_phys_nxt   = out_phys_r;
    out_status_nxt = out_status_r;
    pool_ctl       = '0;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = {free_frame, 1'b1};
    mem_raddr      = {frame_r, idx_cur};

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          type_nxt = in_req_type;
          va_nxt   = in_virt_addr;
          lv_nxt   = '0;
          frame_nxt = root_frame;
          if (pool_sts.root_present) begin
            state_nxt = S_READ;
          end else if (in_req_type == mlptw_pkg::REQ_TRANSLATE) begin
            out_valid_nxt  = 1'b1;
            out_phys_nxt   = '0;
            out_status_nxt = mlptw_pkg::ST_UNMAPPED;
          end else if (pool_sts.avail) begin
            pool_ctl.take     = 1'b1;
            pool_ctl.set_root = 1'b1;
            frame_nxt         = free_frame;
            state_nxt         = S_READ;
          end else begin
            out_valid_nxt  = 1'b1;
            out_phys_nxt   = '0;
            out_status_nxt = mlptw_pkg::ST_EXHAUSTED;
          end
        end
      end
      S_READ: begin
        addr_nxt  = {frame_r, idx_cur};
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (entry_present) begin
          frame_nxt = entry_frame;
          if (last_level) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = mlptw_pkg::ST_OK;
            out_phys_nxt   = (type_r == mlptw_pkg::REQ_TRANSLATE)
                             ? phys_full[mlptw_pkg::PHYS_W-1:0] : '0;
          end else begin
            lv_nxt    = lv_r + LW'(1);
            state_nxt = S_READ;
          end
        end else if (type_r == mlptw_pkg::REQ_TRANSLATE) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_phys_nxt   = '0;
          out_status_nxt = mlptw_pkg::ST_UNMAPPED;
        end else if (pool_sts.avail) begin
          // link a fresh frame and carry on
          mem_we        = 1'b1;
          pool_ctl.take = 1'b1;
          frame_nxt     = free_frame;
          if (last_level) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_phys_nxt   = '0;
            out_status_nxt = mlptw_pkg::ST_OK;
          end else begin
            lv_nxt    = lv_r + LW'(1);
            state_nxt = S_READ;
          end
        end else begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_phys_nxt   = '0;
          out_status_nxt = mlptw_pkg::ST_EXHAUSTED;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      lv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      lv_r        <= lv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r      <= frame_nxt;
    type_r       <= type_nxt;
    va_r         <= va_nxt;
    addr_r       <= addr_nxt;
    out_phys_r   <= out_phys_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy          = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_phys_addr = out_phys_r;
  assign out_status    = out_status_r;

endmodule

// ----- hw/rtl/multilevel_page_table_walker_unit.sv -----
// ============================================================================
// multilevel_page_table_walker_unit
// Multi-level page table walker with a sequential frame pool.
// Walk: a full walk does one entry read and one check per level, and the
//   result strobe is registered; a walk ends early on a miss.
// Requests: a new request is taken only while busy is low, once the walk
//   before it is done. Results are strobed for one cycle; no stall.
// Reset: a clearing pass writes zero to all FRAME_COUNT*2^(PAGE_OFFSET_BITS-3)
//   words of the entry RAM; busy stays high until it ends.
// ============================================================================
module multilevel_page_table_walker_unit #(
  parameter int LEVEL_COUNT      = mlptw_pkg::LEVEL_COUNT_DEF,
  parameter int PAGE_OFFSET_BITS = mlptw_pkg::PAGE_OFFSET_BITS_DEF,
  parameter int FRAME_COUNT      = mlptw_pkg::FRAME_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [mlptw_pkg::VA_W-1:0]     in_virt_addr,
  output logic                           out_valid,
  output logic [mlptw_pkg::PHYS_W-1:0]   out_phys_addr,
  output logic [mlptw_pkg::STATUS_W-1:0] out_status
);

  localparam int FB    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int IDX_W = PAGE_OFFSET_BITS - mlptw_pkg::PTE_BITS;
  localparam int EW    = FB + 1;
  localparam int AW    = FB + IDX_W;
  localparam int DEPTH = FRAME_COUNT * (2 ** IDX_W);

  mlptw_pkg::pool_ctl_t pool_ctl;
  mlptw_pkg::pool_sts_t pool_sts;
  logic [FB-1:0]        free_frame;
  logic [FB-1:0]        root_frame;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [EW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [EW-1:0]        mem_rdata;

  mlptw_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mlptw_pool #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pool_ctl),
    .sts        (pool_sts),
    .free_frame (free_frame),
    .root_frame (root_frame)
  );

  mlptw_walk #(
    .LEVEL_COUNT      (LEVEL_COUNT),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
    .FRAME_COUNT      (FRAME_COUNT)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_virt_addr  (in_virt_addr),
    .out_valid     (out_valid),
    .out_phys_addr (out_phys_addr),
    .out_status    (out_status),
    .pool_ctl      (pool_ctl),
    .pool_sts      (pool_sts),
    .free_frame    (free_frame),
    .root_frame    (root_frame),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mlptw_pkg::ST_OK |-> out_phys_addr == '0)
    else $error("failed request returned a non-zero address");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(start && !busy) |=> !out_valid)
    else $error("result strobe without a matching transfer");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && pool_sts.root_present |=> busy)
    else $error("walk transfer did not raise busy");

  a_pool_take: assert property (@(posedge clk) disable iff (!rst_n)
    pool_ctl.set_root |-> pool_ctl.take && !pool_sts.root_present)
    else $error("root frame set outside a first allocate");

endmodule

// ----- verif/mlptw_walk_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page table walk checker
// Watches request and result transfers of the page table walker. Every
// accepted request is walked against a private copy of the entry store,
// root and frame pool. The expected status and physical address are queued
// and then compared in order with the strobed results.
// ----------------------------------------------------------------------------
module mlptw_walk_checker
  import mlptw_pkg::*;
#(
  parameter int LEVEL_COUNT      = LEVEL_COUNT_DEF,
  parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF,
  parameter int FRAME_COUNT      = FRAME_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_req_type,
  input  logic [VA_W-1:0]     in_virt_addr,
  input  logic                out_valid,
  input  logic [PHYS_W-1:0]   out_phys_addr,
  input  logic [STATUS_W-1:0] out_status,
  output int                  mismatches,
  output int                  pending
);

  localparam int IDX_W      = PAGE_OFFSET_BITS - PTE_BITS;
  localparam int TABLE_SIZE = 1 << IDX_W;
  localparam int FRAME_W    = $clog2(FRAME_COUNT);
  localparam int POOL_W     = $clog2(FRAME_COUNT + 1);

  typedef struct packed {
    logic [PHYS_W-1:0]   phys;
    logic [STATUS_W-1:0] status;
  } walk_result_t;

  bit [FRAME_W:0]    pte_store [FRAME_COUNT*TABLE_SIZE];
  bit                root_valid;
  bit [FRAME_W-1:0]  root_frame;
  bit [POOL_W-1:0]   free_frame;
  walk_result_t      expected_q [$];

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned table_index(input logic [VA_W-1:0] va, input int lv);
    int sh;
    sh = PAGE_OFFSET_BITS + IDX_W * (LEVEL_COUNT - 1 - lv);
    if (sh >= VA_W) return 0;
    return int'((va >> sh) & (TABLE_SIZE - 1));
  endfunction

  function automatic bit claim_frame(output bit [FRAME_W-1:0] f);
    f = '0;
    if (free_frame >= FRAME_COUNT) return 1'b0;
    f = free_frame[FRAME_W-1:0];
    free_frame++;
    return 1'b1;
  endfunction

  function automatic walk_result_t walk(input logic rt, input logic [VA_W-1:0] va);
    bit [FRAME_W-1:0]    frame;
    bit [FRAME_W-1:0]    nf;
    bit [FRAME_W:0]      pte;
    int unsigned         slot;
    logic [STATUS_W-1:0] st;
    logic [63:0]         phys;
    walk_result_t        r;
    st   = ST_OK;
    phys = '0;
    if (rt == REQ_TRANSLATE) begin
      if (!root_valid) begin
        st = ST_UNMAPPED;
      end else begin
        frame = root_frame;
        for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
          if (frame >= FRAME_COUNT) begin
            st = ST_UNMAPPED;
            break;
          end
          pte = pte_store[frame * TABLE_SIZE + table_index(va, lv)];
          if (!pte[0]) begin
            st = ST_UNMAPPED;
            break;
          end
          frame = pte[FRAME_W:1];
        end
        if (st == ST_OK)
          phys = (64'(frame) << PAGE_OFFSET_BITS) |
                 (64'(va) & ((64'd1 << PAGE_OFFSET_BITS) - 1));
      end
    end else begin
      if (!root_valid) begin
        if (claim_frame(nf)) begin
          root_frame = nf;
          root_valid = 1'b1;
        end else begin
          st = ST_EXHAUSTED;
        end
      end
      if (st == ST_OK) begin
        frame = root_frame;
        for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
          if (frame >= FRAME_COUNT) begin
            st = ST_UNMAPPED;
            break;
          end
          slot = frame * TABLE_SIZE + table_index(va, lv);
          pte  = pte_store[slot];
          if (!pte[0]) begin
            if (!claim_frame(nf)) begin
              st = ST_EXHAUSTED;
              break;
            end
            pte = {nf, 1'b1};
            pte_store[slot] = pte;
          end
          frame = pte[FRAME_W:1];
        end
      end
    end
    r.phys   = (st == ST_OK) ? phys[PHYS_W-1:0] : '0;
    r.status = st;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    walk_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing outstanding: phys %h status %0d",
                                  out_phys_addr, out_status));
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_phys_addr !== want.phys)
            flag_mismatch($sformatf("phys_addr %h, expected %h", out_phys_addr, want.phys));
        end
      end
      if (start && !busy) expected_q.push_back(walk(in_req_type, in_virt_addr));
    end
    pending <= expected_q.size();
  end

endmodule

// ----- verif/multilevel_page_table_walker_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page table walker testbench
// Drives translate and allocate requests in random bursts: a directed opening
// over empty tables, mapped and unmapped addresses and repeated allocation,
// then random requests built mostly on already mapped addresses, and finally
// enough fresh allocations to run the frame pool dry. Results are checked by
// the walk checker beside the block.
// ----------------------------------------------------------------------------
module multilevel_page_table_walker_unit_test;
  import mlptw_pkg::*;

  localparam int LC  = LEVEL_COUNT_DEF;
  localparam int POB = PAGE_OFFSET_BITS_DEF;
  localparam int FC  = FRAME_COUNT_DEF;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                start        = 1'b0;
  logic                in_req_type  = REQ_TRANSLATE;
  logic [VA_W-1:0]     in_virt_addr = '0;
  logic                busy;
  logic                out_valid;
  logic [PHYS_W-1:0]   out_phys_addr;
  logic [STATUS_W-1:0] out_status;
  int                  mismatches;
  int                  pending;
  int                  burst_left = 0;
  logic [VA_W-1:0]     mapped_va [$];

  always #1 clk = ~clk;

  multilevel_page_table_walker_unit #(
    .LEVEL_COUNT(LC), .PAGE_OFFSET_BITS(POB), .FRAME_COUNT(FC)
  ) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_virt_addr(in_virt_addr),
    .out_valid(out_valid), .out_phys_addr(out_phys_addr), .out_status(out_status)
  );

  mlptw_walk_checker #(
    .LEVEL_COUNT(LC), .PAGE_OFFSET_BITS(POB), .FRAME_COUNT(FC)
  ) walk_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_virt_addr(in_virt_addr),
    .out_valid(out_valid), .out_phys_addr(out_phys_addr), .out_status(out_status),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // keep the upper levels of a mapped address, randomise the rest
  function automatic logic [VA_W-1:0] pick_va(input int keep);
    logic [63:0]     fill;
    logic [63:0]     low_mask;
    logic [VA_W-1:0] base;
    int              cut;
    fill = {$urandom, $urandom};
    if (mapped_va.size() == 0 || keep == 0) return fill[VA_W-1:0];
    base     = mapped_va[$urandom_range(mapped_va.size() - 1)];
    cut      = POB + (POB - PTE_BITS) * (LC - keep);
    low_mask = (64'd1 << cut) - 1;
    return (base & ~low_mask[VA_W-1:0]) | (fill[VA_W-1:0] & low_mask[VA_W-1:0]);
  endfunction

  function automatic int pick_keep();
    if ($urandom_range(9) == 0) return 0;
    if ($urandom_range(3) == 0) return $urandom_range(1, LC);
    return LC - $urandom_range(1);
  endfunction

  task automatic idle(input int cycles);
    start        <= 1'b0;
    in_req_type  <= $urandom_range(1);
    in_virt_addr <= {$urandom, $urandom};
    repeat (cycles) @(posedge clk);
  endtask

  // hold the request until the transfer edge
  task automatic send(input logic rt, input logic [VA_W-1:0] va);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) idle(gap);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start        <= 1'b1;
    in_req_type  <= rt;
    in_virt_addr <= va;
    do @(posedge clk); while (busy);
    if (rt == REQ_ALLOCATE && mapped_va.size() < 4096) mapped_va.push_back(va);
  endtask

  initial begin
    logic rt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send(REQ_TRANSLATE, 48'h0000_0000_0000);
    send(REQ_TRANSLATE, 48'hFFFF_FFFF_FFFF);
    send(REQ_ALLOCATE,  48'hFFFF_FFFF_FFFF);
    send(REQ_TRANSLATE, 48'hFFFF_FFFF_FFFF);
    send(REQ_ALLOCATE,  48'hFFFF_FFFF_FFFF);
    send(REQ_TRANSLATE, 48'hFFFF_FFFF_EFFF);
    send(REQ_TRANSLATE, 48'h7FFF_FFFF_FFFF);
    send(REQ_ALLOCATE,  48'h0000_0000_0000);
    send(REQ_TRANSLATE, 48'h0000_0000_0000);
    send(REQ_TRANSLATE, 48'h0000_0000_0ABC);
    send(REQ_ALLOCATE,  48'h0000_0000_1000);
    send(REQ_TRANSLATE, 48'h0000_0000_1FFF);
    send(REQ_TRANSLATE, 48'h0000_0020_0000);
    send(REQ_ALLOCATE,  48'h8000_0000_0000);
    send(REQ_TRANSLATE, 48'h8000_0000_0123);
    send(REQ_ALLOCATE,  48'hAAAA_AAAA_AAAA);
    send(REQ_TRANSLATE, 48'hAAAA_AAAA_A555);
    send(REQ_TRANSLATE, 48'h5555_5555_5555);

    repeat (1000) begin
      rt = ($urandom_range(9) < 3) ? REQ_ALLOCATE : REQ_TRANSLATE;
      send(rt, pick_va(pick_keep()));
    end

    // drain the frame pool, then look up what survived
    repeat (70) send(REQ_ALLOCATE, pick_va(0));
    repeat (30) send(REQ_TRANSLATE, pick_va(pick_keep()));

    idle(1);
    while (pending != 0) @(posedge clk);
    repeat (2 * LC + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
